// File: src/assert_macros.svh
// Assertion macros shared by the radial vignetting gain RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, disabled while reset is active.
`define RVG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at each rising clock edge, also during reset.
`define RVG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rvg_pkg.sv
// Package for the radial vignetting gain block: widths, register codes,
// configuration struct and reset values. No dependencies.
package rvg_pkg;

  localparam int PixBits    = 8;
  localparam int CoordBits  = 12;
  localparam int DimBits    = 13;
  localparam int CoefBits   = 16;
  localparam int NormBits   = 48;
  localparam int NormHalf   = 24;
  localparam int SqBits     = 2 * DimBits;
  localparam int DistBits   = SqBits + 1;
  localparam int PartBits   = DistBits + NormHalf;
  localparam int R2Bits     = 17;
  localparam int R4Bits     = 18;
  localparam int R6Bits     = 19;
  localparam int Ar2Bits    = CoefBits + R2Bits + 1;
  localparam int Br4Bits    = CoefBits + R4Bits + 1;
  localparam int Cr6Bits    = CoefBits + R6Bits + 1;
  localparam int SabBits    = Cr6Bits;
  localparam int GainFrac   = 26;
  localparam int GainBits   = 38;
  localparam int ProdBits   = GainBits + PixBits + 1;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = NormBits;

  localparam logic [R2Bits-1:0]   R2Sat   = '1;
  localparam logic [PixBits-1:0]  PixMax  = '1;
  localparam logic signed [GainBits-1:0] GainOne = GainBits'(64'd1 << GainFrac);

  localparam logic [DimBits-1:0]  WidthReset  = DimBits'(640);
  localparam logic [DimBits-1:0]  HeightReset = DimBits'(480);
  localparam logic [NormBits-1:0] NormReset   = NormBits'(64'd458129844);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_COEF_A = 3'd0,
    CFG_COEF_B = 3'd1,
    CFG_COEF_C = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4,
    CFG_NORM   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoefBits-1:0] coef_a;
    logic signed [CoefBits-1:0] coef_b;
    logic signed [CoefBits-1:0] coef_c;
    logic [DimBits-1:0]         image_width;
    logic [DimBits-1:0]         image_height;
    logic [NormBits-1:0]        radius_norm;
  } cfg_t;

endpackage

// File: src/rvg_ifs.sv
// Valid/ready channel interfaces for the radial vignetting gain block.
// Depends on rvg_pkg for the payload widths.
interface rvg_in_if;
  logic                          valid;
  logic                          ready;
  logic [rvg_pkg::PixBits-1:0]   pixel_in;
  logic [rvg_pkg::CoordBits-1:0] row_index;
  logic [rvg_pkg::CoordBits-1:0] col_index;

  modport source (output valid, pixel_in, row_index, col_index, input ready);
  modport sink   (input valid, pixel_in, row_index, col_index, output ready);
endinterface

interface rvg_out_if;
  logic                        valid;
  logic                        ready;
  logic [rvg_pkg::PixBits-1:0] pixel_out;
  logic                        clipped;

  modport source (output valid, pixel_out, clipped, input ready);
  modport sink   (input valid, pixel_out, clipped, output ready);
endinterface

// File: src/rvg_radius.sv
// Squared radius pipeline: distance from center, scaled by the reciprocal norm.
// Four register stages; depends on rvg_pkg.
module rvg_radius (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  rvg_pkg::cfg_t                   cfg_i,
  input  logic                            vld_i,
  input  logic [rvg_pkg::PixBits-1:0]     pix_i,
  input  logic [rvg_pkg::CoordBits-1:0]   row_i,
  input  logic [rvg_pkg::CoordBits-1:0]   col_i,
  output logic                            vld_o,
  output logic [rvg_pkg::PixBits-1:0]     pix_o,
  output logic [rvg_pkg::R2Bits-1:0]      r2_o
);
  import rvg_pkg::*;

  localparam int NStages = 4;
  localparam int SumBits = PartBits + 1;

  logic [NStages-1:0]   vld_q;
  logic [PixBits-1:0]   pix_q [NStages];
  logic [DimBits-1:0]   two_col, two_row, dcol, drow;
  logic [SqBits-1:0]    sq_col_q, sq_row_q;
  logic [DistBits-1:0]  dist_q;
  logic [PartBits-1:0]  lo_q, hi_q;
  logic [SumBits-1:0]   sum;
  logic [SumBits-9:0]   quo;
  logic [R2Bits-1:0]    r2_d, r2_q;

  assign two_col = {col_i, 1'b0};
  assign two_row = {row_i, 1'b0};
  assign dcol = (two_col >= cfg_i.image_width) ? two_col - cfg_i.image_width
                                               : cfg_i.image_width - two_col;
  assign drow = (two_row >= cfg_i.image_height) ? two_row - cfg_i.image_height
                                                : cfg_i.image_height - two_row;

  assign sum  = SumBits'(hi_q) + SumBits'(lo_q >> NormHalf);
  assign quo  = sum[SumBits-1:8];
  assign r2_d = (|quo[SumBits-9:R2Bits]) ? R2Sat : quo[R2Bits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NStages-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pix_q[0] <= pix_i;
      for (int i = 1; i < NStages; i++) begin
        pix_q[i] <= pix_q[i-1];
      end
      sq_col_q <= dcol * dcol;
      sq_row_q <= drow * drow;
      dist_q   <= DistBits'(sq_col_q) + DistBits'(sq_row_q);
      lo_q     <= dist_q * cfg_i.radius_norm[NormHalf-1:0];
      hi_q     <= dist_q * cfg_i.radius_norm[NormBits-1:NormHalf];
      r2_q     <= r2_d;
    end
  end

  assign vld_o = vld_q[NStages-1];
  assign pix_o = pix_q[NStages-1];
  assign r2_o  = r2_q;

endmodule

// File: src/rvg_poly.sv
// Gain polynomial pipeline: r4, r6 and 1 + a*r2 + b*r4 + c*r6 in Q26.
// Four register stages; depends on rvg_pkg.
module rvg_poly (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  rvg_pkg::cfg_t                        cfg_i,
  input  logic                                 vld_i,
  input  logic [rvg_pkg::PixBits-1:0]          pix_i,
  input  logic [rvg_pkg::R2Bits-1:0]           r2_i,
  output logic                                 vld_o,
  output logic [rvg_pkg::PixBits-1:0]          pix_o,
  output logic signed [rvg_pkg::GainBits-1:0]  gain_o
);
  import rvg_pkg::*;

  localparam int NStages = 4;
  localparam logic [2*R2Bits:0]       HalfSq  = (2*R2Bits+1)'(1 << 15);
  localparam logic [R4Bits+R2Bits:0]  HalfCub = (R4Bits+R2Bits+1)'(1 << 15);

  logic [NStages-1:0]          vld_q;
  logic [PixBits-1:0]          pix_q [NStages];
  logic [R2Bits-1:0]           r2_q;
  logic [R4Bits-1:0]           r4_q;
  logic [R6Bits-1:0]           r6_q;
  logic [2*R2Bits:0]           sq_rnd;
  logic [R4Bits+R2Bits:0]      cub_rnd;
  logic signed [Ar2Bits-1:0]   ar2_d, ar2_q, ar2_p2_q;
  logic signed [Br4Bits-1:0]   br4_d, br4_q;
  logic signed [Cr6Bits-1:0]   cr6_d, cr6_q;
  logic signed [SabBits-1:0]   sab_d, sab_q;
  logic signed [GainBits-1:0]  gain_d, gain_q;

  assign sq_rnd  = (2*R2Bits+1)'(r2_i) * (2*R2Bits+1)'(r2_i) + HalfSq;
  assign ar2_d   = cfg_i.coef_a * $signed({1'b0, r2_i});
  assign cub_rnd = (R4Bits+R2Bits+1)'(r4_q) * (R4Bits+R2Bits+1)'(r2_q) + HalfCub;
  assign br4_d   = cfg_i.coef_b * $signed({1'b0, r4_q});
  assign cr6_d   = cfg_i.coef_c * $signed({1'b0, r6_q});
  assign sab_d   = {{(SabBits-Ar2Bits){ar2_p2_q[Ar2Bits-1]}}, ar2_p2_q}
                 + {{(SabBits-Br4Bits){br4_q[Br4Bits-1]}}, br4_q};
  assign gain_d  = GainOne
                 + {{(GainBits-SabBits){sab_q[SabBits-1]}}, sab_q}
                 + {{(GainBits-Cr6Bits){cr6_q[Cr6Bits-1]}}, cr6_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NStages-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pix_q[0] <= pix_i;
      for (int i = 1; i < NStages; i++) begin
        pix_q[i] <= pix_q[i-1];
      end
      r2_q     <= r2_i;
      r4_q     <= sq_rnd[2*R2Bits-1:16];
      ar2_q    <= ar2_d;
      r6_q     <= cub_rnd[R4Bits+R2Bits-1:16];
      br4_q    <= br4_d;
      ar2_p2_q <= ar2_q;
      cr6_q    <= cr6_d;
      sab_q    <= sab_d;
      gain_q   <= gain_d;
    end
  end

  assign vld_o  = vld_q[NStages-1];
  assign pix_o  = pix_q[NStages-1];
  assign gain_o = gain_q;

endmodule

// File: src/rvg_scale.sv
// Pixel scaling: multiply by the gain, round, saturate, and hold the result
// in the output register. Depends on rvg_pkg, rvg_ifs and assert_macros.svh.
`include "assert_macros.svh"

module rvg_scale (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  output logic                                 adv_o,
  input  logic                                 vld_i,
  input  logic [rvg_pkg::PixBits-1:0]          pix_i,
  input  logic signed [rvg_pkg::GainBits-1:0]  gain_i,
  rvg_out_if.source                            rsp_o
);
  import rvg_pkg::*;

  localparam int VBits = ProdBits + 1 - GainFrac;
  localparam logic [ProdBits:0] Half = (ProdBits+1)'(64'd1 << (GainFrac - 1));

  logic                        adv;
  logic                        prod_vld_q;
  logic signed [ProdBits-1:0]  prod_q;
  logic [ProdBits-1:0]         mag;
  logic [ProdBits:0]           rnd;
  logic [VBits-1:0]            val;
  logic                        neg;
  logic                        out_vld_q;
  logic [PixBits-1:0]          out_pix_d, out_pix_q;
  logic                        out_clip_d, out_clip_q;

  assign adv   = !out_vld_q || rsp_o.ready;
  assign adv_o = adv;

  assign neg = prod_q[ProdBits-1];
  assign mag = neg ? ProdBits'(-prod_q) : ProdBits'(prod_q);
  assign rnd = (ProdBits+1)'(mag) + Half;
  assign val = rnd[ProdBits:GainFrac];

  always_comb begin
    if (neg) begin
      out_pix_d  = '0;
      out_clip_d = |val;
    end else if (val > VBits'(PixMax)) begin
      out_pix_d  = PixMax;
      out_clip_d = 1'b1;
    end else begin
      out_pix_d  = val[PixBits-1:0];
      out_clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (adv) begin
      prod_vld_q <= vld_i;
      out_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q     <= $signed({1'b0, pix_i}) * gain_i;
      out_pix_q  <= out_pix_d;
      out_clip_q <= out_clip_d;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.pixel_out = out_pix_q;
  assign rsp_o.clipped   = out_clip_q;

  `RVG_ASSERT(a_clip_at_rail, clk_i, rst_ni, (out_vld_q && out_clip_q) |-> (out_pix_q == '0 || out_pix_q == PixMax), "clipped pixel is not at a rail")
  `RVG_ASSERT(a_prod_to_out, clk_i, rst_ni, (adv && prod_vld_q) |=> out_vld_q, "product stage request not moved to output")
  `RVG_ASSERT(a_prod_hold, clk_i, rst_ni, (prod_vld_q && !adv) |=> (prod_vld_q && $stable(prod_q)), "product stage changed during stall")

endmodule

// File: src/radial_vignetting_gain_top.sv
// Radial lens-shading gain for a gray pixel stream: one request per clock
// while the output is not stalled. An accepted request passes the squared
// radius stages, the gain polynomial stages, the pixel product register and
// the rounding into the output register. A stall at the output freezes every
// stage at once, so nothing is lost or repeated. Registers are written through
// the plain write port and are read by the pipeline directly; write them only
// while no request is in flight. Depends on rvg_pkg, rvg_ifs and the rvg_* stages.
module radial_vignetting_gain_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rvg_in_if.sink                            req_i,
  rvg_out_if.source                         rsp_o,
  input  logic                              cfg_we_i,
  input  logic [rvg_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [rvg_pkg::CfgDataBits-1:0]   cfg_data_i
);
  import rvg_pkg::*;

  cfg_t                        cfg_q;
  logic                        adv;
  logic                        rad_vld, poly_vld;
  logic [PixBits-1:0]          rad_pix, poly_pix;
  logic [R2Bits-1:0]           rad_r2;
  logic signed [GainBits-1:0]  poly_gain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a       <= '0;
      cfg_q.coef_b       <= '0;
      cfg_q.coef_c       <= '0;
      cfg_q.image_width  <= WidthReset;
      cfg_q.image_height <= HeightReset;
      cfg_q.radius_norm  <= NormReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_A: cfg_q.coef_a       <= cfg_data_i[CoefBits-1:0];
        CFG_COEF_B: cfg_q.coef_b       <= cfg_data_i[CoefBits-1:0];
        CFG_COEF_C: cfg_q.coef_c       <= cfg_data_i[CoefBits-1:0];
        CFG_WIDTH:  cfg_q.image_width  <= cfg_data_i[DimBits-1:0];
        CFG_HEIGHT: cfg_q.image_height <= cfg_data_i[DimBits-1:0];
        CFG_NORM:   cfg_q.radius_norm  <= cfg_data_i[NormBits-1:0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = adv;

  rvg_radius u_radius (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg_q),
    .vld_i  (req_i.valid),
    .pix_i  (req_i.pixel_in),
    .row_i  (req_i.row_index),
    .col_i  (req_i.col_index),
    .vld_o  (rad_vld),
    .pix_o  (rad_pix),
    .r2_o   (rad_r2)
  );

  rvg_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg_q),
    .vld_i  (rad_vld),
    .pix_i  (rad_pix),
    .r2_i   (rad_r2),
    .vld_o  (poly_vld),
    .pix_o  (poly_pix),
    .gain_o (poly_gain)
  );

  rvg_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_o  (adv),
    .vld_i  (poly_vld),
    .pix_i  (poly_pix),
    .gain_i (poly_gain),
    .rsp_o  (rsp_o)
  );

endmodule

// File: verif/radial_vignetting_gain_top_tb.sv
// Self-checking testbench for radial_vignetting_gain_top: random valid/ready traffic,
// register phases and a scoreboard class that predicts each corrected pixel.
// Depends on rvg_pkg, rvg_ifs and the radial_vignetting_gain_top RTL.
`timescale 1ns / 100ps

module radial_vignetting_gain_top_tb;
  import rvg_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 14;
  localparam int HoldAfter     = 300;
  localparam int HoldCycles    = 400;
  localparam int RandomPhases  = 10;
  localparam int PhaseItems    = 83;
  localparam logic [CfgIdxBits-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgSpareHi = 3'd7;

  typedef struct {
    logic [PixBits-1:0] pixel;
    logic               clipped;
  } shaded_pixel_t;

  class pixel_gain_scoreboard;
    logic signed [CoefBits-1:0] coef_a, coef_b, coef_c;
    logic [DimBits-1:0]         width, height;
    logic [NormBits-1:0]        norm;
    shaded_pixel_t              expected_pixels[$];
    int                         errors;

    function new();
      coef_a = '0;
      coef_b = '0;
      coef_c = '0;
      width  = WidthReset;
      height = HeightReset;
      norm   = NormReset;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
      case (idx)
        CFG_COEF_A: coef_a = data[CoefBits-1:0];
        CFG_COEF_B: coef_b = data[CoefBits-1:0];
        CFG_COEF_C: coef_c = data[CoefBits-1:0];
        CFG_WIDTH:  width  = data[DimBits-1:0];
        CFG_HEIGHT: height = data[DimBits-1:0];
        CFG_NORM:   norm   = data[NormBits-1:0];
        default: ;
      endcase
    endfunction

    function shaded_pixel_t corrected_pixel(logic [PixBits-1:0] pix,
                                            logic [CoordBits-1:0] row,
                                            logic [CoordBits-1:0] col);
      longint unsigned tx, ty, w, h, dx, dy, dist_sq, r2, r4, r6, mag, half;
      logic [79:0]     scaled;
      longint          gain, prod, val;
      shaded_pixel_t   res;
      tx = longint'(col) * 2;
      ty = longint'(row) * 2;
      w  = longint'(width);
      h  = longint'(height);
      dx = (tx >= w) ? tx - w : w - tx;
      dy = (ty >= h) ? ty - h : h - ty;
      dist_sq = dx * dx + dy * dy;
      scaled = (80'(dist_sq) * 80'(norm)) >> 32;
      r2 = (scaled > 80'(R2Sat)) ? longint'(R2Sat) : longint'(scaled[R2Bits-1:0]);
      r4 = (r2 * r2 + 64'h8000) >> 16;
      r6 = (r4 * r2 + 64'h8000) >> 16;
      gain = (longint'(1) << GainFrac) + longint'(coef_a) * longint'(r2)
           + longint'(coef_b) * longint'(r4) + longint'(coef_c) * longint'(r6);
      prod = longint'({56'd0, pix}) * gain;
      half = 64'd1 << (GainFrac - 1);
      if (prod >= 0) begin
        val = longint'((longint'(prod) + half) >> GainFrac);
      end else begin
        mag = -prod;
        val = -longint'((mag + half) >> GainFrac);
      end
      if (val < 0) begin
        res.pixel   = '0;
        res.clipped = 1'b1;
      end else if (val > longint'(PixMax)) begin
        res.pixel   = PixMax;
        res.clipped = 1'b1;
      end else begin
        res.pixel   = val[PixBits-1:0];
        res.clipped = 1'b0;
      end
      return res;
    endfunction

    function void note_request(logic [PixBits-1:0] pix, logic [CoordBits-1:0] row,
                               logic [CoordBits-1:0] col);
      expected_pixels.push_back(corrected_pixel(pix, row, col));
    endfunction

    function void check_result(logic [PixBits-1:0] pix, logic clipped);
      shaded_pixel_t exp_px;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result pixel_out=%0d clipped=%0b", $time, pix, clipped);
        errors++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (pix !== exp_px.pixel) begin
        $display("%0t: pixel_out mismatch expected=%0d actual=%0d",
                 $time, exp_px.pixel, pix);
        errors++;
      end
      if (clipped !== exp_px.clipped) begin
        $display("%0t: clipped mismatch expected=%0b actual=%0b",
                 $time, exp_px.clipped, clipped);
        errors++;
      end
    endfunction

    function int pending_count();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  rvg_in_if  req_if ();
  rvg_out_if rsp_if ();

  radial_vignetting_gain_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  pixel_gain_scoreboard board;
  bit steady_src;
  bit steady_snk;
  bit held_off;
  int results_seen;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[47:0];
  endfunction

  function automatic logic [NormBits-1:0] norm_for(logic [DimBits-1:0] w,
                                                   logic [DimBits-1:0] h);
    longint unsigned d;
    d = longint'(w) * longint'(w) + longint'(h) * longint'(h);
    if (d == 0) return 48'h8000_0000_0000;
    return 48'(((64'd1 << 48) + d / 2) / d);
  endfunction

  function automatic logic signed [CoefBits-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom());
      1:       return '0;
      default: return 16'($urandom_range(0, 4096)) - 16'sd2048;
    endcase
  endfunction

  function automatic logic [DimBits-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 13'd4096;
      1:       return 13'($urandom_range(0, 3));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [NormBits-1:0] pick_norm(logic [DimBits-1:0] w,
                                                    logic [DimBits-1:0] h);
    case ($urandom_range(0, 7))
      0:       return rand48();
      1:       return '0;
      2:       return 48'h8000_0000_0000;
      default: return norm_for(w, h);
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  task automatic apply_config(input logic signed [CoefBits-1:0] a, b, c,
                              input logic [DimBits-1:0] w, h,
                              input logic [NormBits-1:0] norm);
    logic [47:0] noise;
    noise = rand48();
    write_reg(CFG_COEF_A, {noise[47:16], a});
    noise = rand48();
    write_reg(CFG_COEF_B, {noise[47:16], b});
    noise = rand48();
    write_reg(CFG_COEF_C, {noise[47:16], c});
    noise = rand48();
    write_reg(CFG_WIDTH, {noise[47:13], w});
    noise = rand48();
    write_reg(CFG_HEIGHT, {noise[47:13], h});
    write_reg(CFG_NORM, norm);
    write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, rand48());
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PixBits-1:0] pix,
                            input logic [CoordBits-1:0] row, col);
    int gap;
    gap = steady_src ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.pixel_in  <= pix;
    req_if.row_index <= row;
    req_if.col_index <= col;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain_pipeline();
    req_if.valid <= 1'b0;
    while (board.pending_count() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        board.note_request(req_if.pixel_in, req_if.row_index, req_if.col_index);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        board.check_result(rsp_if.pixel_out, rsp_if.clipped);
        results_seen++;
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("radial_vignetting_gain_top_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && results_seen >= HoldAfter) begin
        held_off = 1'b1;
        stall    = HoldCycles;
      end else begin
        stall = steady_snk ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  initial begin
    logic [CoordBits-1:0]       row, col;
    logic [DimBits-1:0]         w, h;
    logic signed [CoefBits-1:0] a, b, c;
    board            = new();
    results_seen     = 0;
    idle_cycles      = 0;
    held_off         = 1'b0;
    steady_src       = 1'b0;
    steady_snk       = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    req_if.valid     = 1'b0;
    req_if.pixel_in  = '0;
    req_if.row_index = '0;
    req_if.col_index = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unit gain out of reset
    send_pixel(0, 0, 0);
    send_pixel(255, 4095, 4095);
    send_pixel(128, 240, 320);
    drain_pipeline();

    // overflow toward 255
    apply_config(16'sd32767, 16'sd32767, 16'sd32767, 640, 480, norm_for(640, 480));
    send_pixel(255, 0, 0);
    send_pixel(1, 240, 320);
    send_pixel(200, 100, 600);
    drain_pipeline();

    // strongly negative gain
    apply_config(16'sh8000, 16'sh8000, 16'sh8000, 640, 480, norm_for(640, 480));
    send_pixel(255, 0, 0);
    send_pixel(0, 0, 0);
    send_pixel(255, 240, 320);
    drain_pipeline();

    // slightly negative gain in the corners: rounds to zero or clips
    apply_config(-16'sd1100, 16'sd0, 16'sd0, 640, 480, norm_for(640, 480));
    send_pixel(1, 0, 0);
    send_pixel(6, 0, 0);
    send_pixel(255, 0, 0);
    drain_pipeline();

    // zero image size, radius saturates far out
    apply_config(16'sd512, -16'sd256, 16'sd128, 0, 0, 48'h8000_0000_0000);
    send_pixel(100, 4095, 4095);
    send_pixel(100, 0, 0);
    send_pixel(77, 1, 1);
    drain_pipeline();

    // largest image
    apply_config(16'sd1024, -16'sd512, 16'sd256, 4096, 4096, norm_for(4096, 4096));
    send_pixel(255, 4095, 0);
    send_pixel(255, 0, 4095);
    send_pixel(50, 2048, 2048);
    drain_pipeline();

    // odd sizes, coordinates outside the image
    apply_config(-16'sd300, 16'sd700, -16'sd900, 7, 3, norm_for(7, 3));
    send_pixel(10, 0, 0);
    send_pixel(10, 4095, 4095);
    send_pixel(90, 1, 3);
    drain_pipeline();

    // largest reciprocal
    apply_config(16'sd300, 16'sd0, 16'sd0, 1, 1, '1);
    send_pixel(10, 0, 0);
    send_pixel(200, 0, 0);
    send_pixel(200, 4095, 0);
    drain_pipeline();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
      w = pick_dim();
      h = pick_dim();
      apply_config(a, b, c, w, h, pick_norm(w, h));
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 32 == 0) begin
          steady_src = ($urandom_range(0, 3) == 0);
          steady_snk = ($urandom_range(0, 3) == 0);
        end
        if (h == 0 || $urandom_range(0, 7) == 0) row = CoordBits'($urandom_range(0, 4095));
        else row = CoordBits'($urandom_range(0, h - 1));
        if (w == 0 || $urandom_range(0, 7) == 0) col = CoordBits'($urandom_range(0, 4095));
        else col = CoordBits'($urandom_range(0, w - 1));
        send_pixel(PixBits'($urandom_range(0, 255)), row, col);
      end
      drain_pipeline();
    end

    if (board.errors == 0) begin
      $display("radial_vignetting_gain_top_tb: PASS");
    end else begin
      $display("radial_vignetting_gain_top_tb: FAIL");
    end
    $finish;
  end

endmodule
